@@ hdl/ppv_pkg.sv @@
// Shared types, constants and the arctangent table for the pursuit velocity block.
package ppv_pkg;

    // Configuration register indexes and port widths
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_LINEAR_GAIN = 2'd0;
    localparam reg_idx_t REG_TURN_GAIN   = 2'd1;
    localparam reg_idx_t REG_TURN_LIMIT  = 2'd2;
    localparam reg_idx_t REG_STOP_RANGE  = 2'd3;

    typedef struct packed {
        logic [15:0] linear_gain;
        logic [15:0] turn_gain;
        logic [17:0] turn_limit;
        logic [15:0] stop_range;
    } cfg_t;

    // Datapath widths
    localparam int CORDIC_W = 27;   // Q.8 scaled position plus growth
    localparam int ANG_W    = 21;   // accumulated angle, Q.16 rad
    localparam int BEAR_W   = 15;   // bearing, Q.12 rad
    localparam int SQ_W     = 32;   // x*x + y*y
    localparam int REM_W    = 19;   // root remainder
    localparam int ROOT_W   = 16;
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int MAX_STEPS  = 24;
    localparam int SQRT_STEPS = 16;

    localparam logic signed [ANG_W-1:0]  PI_Q16 = 21'sd205887;
    localparam logic signed [BEAR_W-1:0] PI_Q12 = 15'sd12868;

    // Multiplier operand selects
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE = 3'd0;
    localparam mul_sel_t MUL_XX   = 3'd1;
    localparam mul_sel_t MUL_YY   = 3'd2;
    localparam mul_sel_t MUL_SS   = 3'd3;
    localparam mul_sel_t MUL_LIN  = 3'd4;
    localparam mul_sel_t MUL_TURN = 3'd5;

    // Branch conditions
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_START    = 3'd1;
    localparam cond_t COND_LOST     = 3'd2;
    localparam cond_t COND_MORE     = 3'd3;
    localparam cond_t COND_OUT_FREE = 3'd4;

    typedef logic [3:0] pc_t;

    // Control word fields seen by the datapath and the top level
    typedef struct packed {
        logic     idle;      // waiting for a word
        logic     ld;        // CORDIC preload, loop counter clear
        logic     sq_load;   // sum := product
        logic     sq_add;    // sum += product
        logic     prep;      // dead zone compare, root init
        logic     iter;      // one CORDIC step and one root bit
        logic     bear;      // round and clamp the bearing
        logic     lin_wr;    // round and saturate the speed
        logic     emit;      // present a result word
        logic     zero;      // result word is all zeros
        mul_sel_t mul_sel;
    } ctrl_t;

    typedef struct packed {
        ctrl_t    ctrl;
        cond_t    cond;
        logic     stay;      // hold pc when the condition is false
        pc_t      target;
    } ucode_t;

    typedef struct packed {
        logic start;         // position word accepted
        logic lost;          // target lost flag
        logic out_free;      // output register can take a word
    } stat_t;

    // atan(2^-i) in Q.16 rad, rounded to nearest
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd51472;
            5'd1:  v = 17'd30386;
            5'd2:  v = 17'd16055;
            5'd3:  v = 17'd8150;
            5'd4:  v = 17'd4091;
            5'd5:  v = 17'd2047;
            5'd6:  v = 17'd1024;
            5'd7:  v = 17'd512;
            5'd8:  v = 17'd256;
            5'd9:  v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ppv_seq.sv @@
// Microcode sequencer: program ROM, program counter, loop counter and branch logic.
module ppv_seq #(
    parameter int CORDIC_STEPS = 16,
    localparam int CSTEPS = (CORDIC_STEPS > ppv_pkg::MAX_STEPS) ?
                            ppv_pkg::MAX_STEPS : CORDIC_STEPS,
    localparam int NITER  = (CSTEPS > ppv_pkg::SQRT_STEPS) ? CSTEPS : ppv_pkg::SQRT_STEPS,
    localparam int CNT_W  = $clog2(NITER + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppv_pkg::stat_t       stat,
    output ppv_pkg::ctrl_t       ctrl,
    output logic [CNT_W-1:0]     cnt
);

    // Program addresses
    localparam ppv_pkg::pc_t PC_IDLE = 4'd0;
    localparam ppv_pkg::pc_t PC_LOAD = 4'd1;
    localparam ppv_pkg::pc_t PC_SQY  = 4'd2;
    localparam ppv_pkg::pc_t PC_SRSQ = 4'd3;
    localparam ppv_pkg::pc_t PC_PREP = 4'd4;
    localparam ppv_pkg::pc_t PC_ITER = 4'd5;
    localparam ppv_pkg::pc_t PC_BEAR = 4'd6;
    localparam ppv_pkg::pc_t PC_TURN = 4'd7;
    localparam ppv_pkg::pc_t PC_FIN  = 4'd8;
    localparam ppv_pkg::pc_t PC_ZERO = 4'd9;

    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(NITER - 1);

    ppv_pkg::pc_t       pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    ppv_pkg::ucode_t    uw;
    logic               cond_true;

    // Program ROM
    always_comb
    begin
        uw = '0;
        unique case (pc_reg)
            PC_IDLE:
            begin
                uw.ctrl.idle = 1'b1;
                uw.cond      = ppv_pkg::COND_START;
                uw.stay      = 1'b1;
                uw.target    = PC_LOAD;
            end
            PC_LOAD:
            begin
                uw.ctrl.ld      = 1'b1;
                uw.ctrl.mul_sel = ppv_pkg::MUL_XX;
                uw.cond         = ppv_pkg::COND_LOST;
                uw.target       = PC_ZERO;
            end
            PC_SQY:
            begin
                uw.ctrl.sq_load = 1'b1;
                uw.ctrl.mul_sel = ppv_pkg::MUL_YY;
            end
            PC_SRSQ:
            begin
                uw.ctrl.sq_add  = 1'b1;
                uw.ctrl.mul_sel = ppv_pkg::MUL_SS;
            end
            PC_PREP:
            begin
                uw.ctrl.prep = 1'b1;
            end
            PC_ITER:
            begin
                uw.ctrl.iter = 1'b1;
                uw.cond      = ppv_pkg::COND_MORE;
                uw.target    = PC_ITER;
            end
            PC_BEAR:
            begin
                uw.ctrl.bear    = 1'b1;
                uw.ctrl.mul_sel = ppv_pkg::MUL_LIN;
            end
            PC_TURN:
            begin
                uw.ctrl.lin_wr  = 1'b1;
                uw.ctrl.mul_sel = ppv_pkg::MUL_TURN;
            end
            PC_FIN:
            begin
                uw.ctrl.emit = 1'b1;
                uw.cond      = ppv_pkg::COND_OUT_FREE;
                uw.stay      = 1'b1;
                uw.target    = PC_IDLE;
            end
            PC_ZERO:
            begin
                uw.ctrl.emit = 1'b1;
                uw.ctrl.zero = 1'b1;
                uw.cond      = ppv_pkg::COND_OUT_FREE;
                uw.stay      = 1'b1;
                uw.target    = PC_IDLE;
            end
            default:
            begin
                uw.cond   = ppv_pkg::COND_OUT_FREE;
                uw.target = PC_IDLE;
            end
        endcase
    end

    // Branch condition
    always_comb
    begin
        case (uw.cond)
            ppv_pkg::COND_START:    cond_true = stat.start;
            ppv_pkg::COND_LOST:     cond_true = stat.lost;
            ppv_pkg::COND_MORE:     cond_true = (cnt_reg != LAST_C);
            ppv_pkg::COND_OUT_FREE: cond_true = stat.out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    // Next address and loop count
    always_comb
    begin
        if (cond_true)
            pc_next = uw.target;
        else if (uw.stay)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 4'd1;

        if (uw.ctrl.ld)
            cnt_next = '0;
        else if (uw.ctrl.iter)
            cnt_next = cnt_reg + CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl = uw.ctrl;
    assign cnt  = cnt_reg;

endmodule

@@ hdl/ppv_dpath.sv @@
// Datapath: shared multiplier, CORDIC vectoring unit, bit-serial square root, result shaping.
module ppv_dpath #(
    parameter int CORDIC_STEPS = 16,
    localparam int CSTEPS = (CORDIC_STEPS > ppv_pkg::MAX_STEPS) ?
                            ppv_pkg::MAX_STEPS : CORDIC_STEPS,
    localparam int NITER  = (CSTEPS > ppv_pkg::SQRT_STEPS) ? CSTEPS : ppv_pkg::SQRT_STEPS,
    localparam int CNT_W  = $clog2(NITER + 1)
) (
    input  logic                        clk,
    input  ppv_pkg::ctrl_t              ctrl,
    input  logic [CNT_W-1:0]            cnt,
    input  logic                        in_load,
    input  logic signed [15:0]          target_x,
    input  logic signed [15:0]          target_y,
    input  ppv_pkg::cfg_t               cfg,
    output logic [15:0]                 res_lin,
    output logic signed [18:0]          res_ang
);

    localparam int CW = ppv_pkg::CORDIC_W;
    localparam int AW = ppv_pkg::ANG_W;
    localparam int BW = ppv_pkg::BEAR_W;
    localparam int PW = ppv_pkg::PROD_W;
    localparam int RW = ppv_pkg::REM_W;
    localparam int QW = ppv_pkg::ROOT_W;

    localparam logic [CNT_W-1:0] CSTEPS_C = CNT_W'(CSTEPS);
    localparam logic [CNT_W-1:0] SQRT_C   = CNT_W'(ppv_pkg::SQRT_STEPS);

    localparam logic signed [AW-1:0] PI12_W  = AW'(ppv_pkg::PI_Q12);
    localparam logic signed [AW-1:0] Z_RND   = AW'(8);
    localparam logic signed [PW-1:0] Q12_RND = PW'(2048);
    localparam logic signed [23:0]   ANG_MAX = 24'sd262143;
    localparam logic signed [23:0]   ANG_MIN = -24'sd262144;

    logic signed [15:0]          x_in_reg, y_in_reg;
    logic signed [CW-1:0]        cx_reg, cy_reg;
    logic signed [AW-1:0]        z_reg;
    logic                        origin_reg;
    logic signed [PW-1:0]        prod_reg;
    logic [ppv_pkg::SQ_W-1:0]    sq_reg;
    logic                        dz_reg;
    logic [RW-1:0]               rem_reg;
    logic [QW-1:0]               root_reg;
    logic signed [BW-1:0]        b_reg;
    logic [15:0]                 lin_reg;

    logic signed [ppv_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]        mul_p;
    logic signed [CW-1:0]        x_sc, y_sc, xs, ys;
    logic signed [AW-1:0]        at, z_rnd, z_clamp;
    logic [RW-1:0]               rem_sh, trial;
    logic signed [PW-1:0]        lin_sum, turn_sum;
    logic [23:0]                 lin_full;
    logic signed [23:0]          turn_q;
    logic signed [18:0]          turn_sat, limit_s;
    logic                        turn_gt;

    // Shared multiplier operand select
    always_comb
    begin
        case (ctrl.mul_sel)
            ppv_pkg::MUL_XX:
            begin
                mul_a = {{2{x_in_reg[15]}}, x_in_reg};
                mul_b = {{2{x_in_reg[15]}}, x_in_reg};
            end
            ppv_pkg::MUL_YY:
            begin
                mul_a = {{2{y_in_reg[15]}}, y_in_reg};
                mul_b = {{2{y_in_reg[15]}}, y_in_reg};
            end
            ppv_pkg::MUL_SS:
            begin
                mul_a = {2'b00, cfg.stop_range};
                mul_b = {2'b00, cfg.stop_range};
            end
            ppv_pkg::MUL_LIN:
            begin
                mul_a = {2'b00, cfg.linear_gain};
                mul_b = {2'b00, root_reg};
            end
            ppv_pkg::MUL_TURN:
            begin
                mul_a = {2'b00, cfg.turn_gain};
                mul_b = {{3{b_reg[BW-1]}}, b_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // CORDIC step terms and root trial
    always_comb
    begin
        x_sc   = {{(CW-24){x_in_reg[15]}}, x_in_reg, 8'b0};
        y_sc   = {{(CW-24){y_in_reg[15]}}, y_in_reg, 8'b0};
        xs     = cx_reg >>> cnt;
        ys     = cy_reg >>> cnt;
        at     = {{(AW-17){1'b0}}, ppv_pkg::atan_q16(5'(cnt))};
        rem_sh = {rem_reg[RW-3:0], sq_reg[ppv_pkg::SQ_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    // Bearing rounding Q.16 to Q.12 and clamp to +-pi
    always_comb
    begin
        z_rnd = (z_reg + Z_RND) >>> 4;
        if (z_rnd > PI12_W)
            z_clamp = PI12_W;
        else if (z_rnd < -PI12_W)
            z_clamp = -PI12_W;
        else
            z_clamp = z_rnd;
    end

    // Output scaling, saturation, dead zone and positive turn cap
    always_comb
    begin
        lin_sum  = prod_reg + Q12_RND;
        lin_full = lin_sum[35:12];
        turn_sum = prod_reg + Q12_RND;
        turn_q   = turn_sum[35:12];
        if (turn_q > ANG_MAX)
            turn_sat = 19'sh3FFFF;
        else if (turn_q < ANG_MIN)
            turn_sat = 19'sh40000;
        else
            turn_sat = turn_q[18:0];
        limit_s = $signed({1'b0, cfg.turn_limit});
        turn_gt = turn_q > $signed({6'b0, cfg.turn_limit});

        if (ctrl.zero)
        begin
            res_lin = '0;
            res_ang = '0;
        end
        else
        begin
            res_lin = dz_reg ? 16'd0 : lin_reg;
            res_ang = dz_reg ? 19'sd0 : turn_sat;
            if (turn_gt)
                res_ang = limit_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            x_in_reg <= target_x;
            y_in_reg <= target_y;
        end

        if (ctrl.mul_sel != ppv_pkg::MUL_NONE)
            prod_reg <= mul_p;

        // CORDIC preload with half-turn for the left half plane
        if (ctrl.ld)
        begin
            origin_reg <= (x_in_reg == 16'sd0) && (y_in_reg == 16'sd0);
            if (x_in_reg[15])
            begin
                cx_reg <= -x_sc;
                cy_reg <= -y_sc;
                z_reg  <= y_in_reg[15] ? -ppv_pkg::PI_Q16 : ppv_pkg::PI_Q16;
            end
            else
            begin
                cx_reg <= x_sc;
                cy_reg <= y_sc;
                z_reg  <= '0;
            end
        end

        // x*x + y*y
        if (ctrl.sq_load)
            sq_reg <= prod_reg[ppv_pkg::SQ_W-1:0];
        if (ctrl.sq_add)
            sq_reg <= sq_reg + prod_reg[ppv_pkg::SQ_W-1:0];

        // dead zone test and root init
        if (ctrl.prep)
        begin
            dz_reg   <= {4'b0, sq_reg} < $unsigned(prod_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end

        if (ctrl.iter)
        begin
            // one vectoring micro-rotation
            if (cnt < CSTEPS_C)
            begin
                if (!cy_reg[CW-1])
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    z_reg  <= z_reg + at;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    z_reg  <= z_reg - at;
                end
            end
            // one root bit, two radicand bits
            if (cnt < SQRT_C)
            begin
                sq_reg <= sq_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[QW-2:0], 1'b0};
                end
            end
        end

        if (ctrl.bear)
            b_reg <= origin_reg ? '0 : z_clamp[BW-1:0];

        if (ctrl.lin_wr)
            lin_reg <= (|lin_full[23:16]) ? 16'hFFFF : lin_full[15:0];
    end

endmodule

@@ hdl/polar_pursuit_velocity.sv @@
// Pursuit velocity top level: ports, configuration registers, lost flag, output register.
//
// Turns a target position (Q8.8 m, relative to the robot) into a forward speed and a
// turn rate with proportional gains on range and bearing; both are zeroed inside the
// stop range, but the turn rate is then capped at turn_limit on the positive side only,
// and that cap overrides the zero. A lost-flag word (cmd = 1) is taken while idle and
// gives no result; while the flag is set each position word passes the load and zero
// steps and gives an all-zero result, then the next word can be taken. A position
// word runs the load, square, dead-zone, iteration, bearing, turn and finish steps before
// the block takes the next word: the loop of the microcode program does one CORDIC
// micro-rotation and one square-root bit per cycle, and one shared 18x18 multiplier
// serves squares, dead-zone limit and both gains in turn. The output register lets a
// new word in while a result still waits to be taken.
module polar_pursuit_velocity #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [ppv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppv_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic signed [15:0]                target_x,
    input  logic signed [15:0]                target_y,
    input  logic                              lost_value,
    // result words
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       linear_velocity,
    output logic signed [18:0]                angular_velocity
);

    localparam int CSTEPS = (CORDIC_STEPS > ppv_pkg::MAX_STEPS) ?
                            ppv_pkg::MAX_STEPS : CORDIC_STEPS;
    localparam int NITER  = (CSTEPS > ppv_pkg::SQRT_STEPS) ? CSTEPS : ppv_pkg::SQRT_STEPS;
    localparam int CNT_W  = $clog2(NITER + 1);

    ppv_pkg::cfg_t          cfg_reg;
    logic                   lost_reg;
    logic                   out_valid_reg;
    logic [15:0]            lin_out_reg;
    logic signed [18:0]     ang_out_reg;

    ppv_pkg::ctrl_t         ctrl;
    ppv_pkg::stat_t         stat;
    logic [CNT_W-1:0]       cnt;
    logic                   in_fire, out_free, emit_fire;
    logic [15:0]            res_lin;
    logic signed [18:0]     res_ang;

    // Handshake glue
    assign in_ready  = ctrl.idle;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = ctrl.emit && out_free;

    assign stat.start    = in_fire && !cmd;
    assign stat.lost     = lost_reg;
    assign stat.out_free = out_free;

    ppv_seq #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .cnt   (cnt)
    );

    ppv_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk      (clk),
        .ctrl     (ctrl),
        .cnt      (cnt),
        .in_load  (stat.start),
        .target_x (target_x),
        .target_y (target_y),
        .cfg      (cfg_reg),
        .res_lin  (res_lin),
        .res_ang  (res_ang)
    );

    // Configuration registers and lost flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_gain <= 16'd819;
            cfg_reg.turn_gain   <= 16'd8192;
            cfg_reg.turn_limit  <= 18'd2145;
            cfg_reg.stop_range  <= 16'd512;
            lost_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ppv_pkg::REG_LINEAR_GAIN: cfg_reg.linear_gain <= cfg_data[15:0];
                    ppv_pkg::REG_TURN_GAIN:   cfg_reg.turn_gain   <= cfg_data[15:0];
                    ppv_pkg::REG_TURN_LIMIT:  cfg_reg.turn_limit  <= cfg_data;
                    ppv_pkg::REG_STOP_RANGE:  cfg_reg.stop_range  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_fire && cmd)
                lost_reg <= lost_value;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            lin_out_reg <= res_lin;
            ang_out_reg <= res_ang;
        end
    end

    assign out_valid        = out_valid_reg;
    assign linear_velocity  = lin_out_reg;
    assign angular_velocity = ang_out_reg;

    // A position word starts the program, so the port closes on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cmd |=> !in_ready)
        else $error("input still open after a position word");

    // Lost flag forces an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit && lost_reg |-> res_lin == 16'd0 && res_ang == 19'sd0)
        else $error("nonzero result while target lost");

    // Turn rate never exceeds the positive cap
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> res_ang <= $signed({1'b0, cfg_reg.turn_limit}))
        else $error("turn rate above cap");

    // A result word only appears from an emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.emit))
        else $error("result word without emit step");

endmodule
